@@ rtl/dtq_pkg.sv @@
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, codes and default sizes for the deadline task queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int TIME_BITS_DEF   = 32;
	localparam int ID_BITS_DEF     = 8;

	// input item kind, carried on s_tuser
	localparam logic ACT_ADD  = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	typedef enum logic [2:0] {
		ST_ADDED    = 3'd0,
		ST_PAST     = 3'd1,
		ST_FULL     = 3'd2,
		ST_RELEASED = 3'd3,
		ST_NONE     = 3'd4
	} dtq_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_RD,
		S_ADD_CMP,
		S_TICK_RD,
		S_TICK_CMP,
		S_DONE
	} dtq_state_t;

endpackage

@@ rtl/dtq_ram.sv @@
// ----------------------------------------------------------------------------
// dtq_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/deadline_task_queue.sv @@
// ----------------------------------------------------------------------------
// deadline_task_queue
// Bounded queue of task ids kept sorted by deadline (ties in arrival order),
// held as a circular sorted list in one RAM.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                    | tuser   | tlast
//  --------+-----+---------------------------------------+---------+-------------
//  s_*     | in  | task_id, deadline, now_time, zero pad | action  | -
//  m_*     | out | released_id, released_deadline, pad   | status  | last result
//
//  Add: take the item; for each queued entry later than the new one, read it,
//  then compare and shift it up one slot; then read and compare once more to
//  place it (a direct write when it lands at the head); then load the result.
//  A rejected add goes straight to the result load.
//  Tick: take the item; for each released task, read the head and compare;
//  then read and compare the first entry not due (no read when the queue runs
//  empty) and load the last result, all on the RAM's single read port.
//  Reset clears the sequencer, head pointer, fill count and output valid; the
//  RAM needs no clearing, since only slots below the fill count are ever read.
//  A new item is taken whenever the sequencer is idle, even while a result
//  still waits on m_*; the sequencer waits only when it must load a result.
//
module deadline_task_queue #(
	parameter int QUEUE_DEPTH = dtq_pkg::QUEUE_DEPTH_DEF,
	parameter int TIME_BITS   = dtq_pkg::TIME_BITS_DEF,
	parameter int ID_BITS     = dtq_pkg::ID_BITS_DEF,
	localparam int IN_W  = ID_BITS + 2 * TIME_BITS,
	localparam int IN_TW = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W  = ID_BITS + TIME_BITS,
	localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [IN_TW-1:0]  s_tdata,   // task_id, deadline, now_time, zero pad
	input  logic              s_tuser,   // action
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [OUT_TW-1:0] m_tdata,   // released_id, released_deadline, zero pad
	output logic [2:0]        m_tuser,   // status
	output logic              m_tlast
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = TIME_BITS + ID_BITS;

	// slot of logical position off, counted from the head, wrapping at depth
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
	                                       input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(base) + (CW+1)'(off);
		if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
			sum = sum - (CW+1)'(QUEUE_DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	// input unpack
	logic [ID_BITS-1:0]   in_id;
	logic [TIME_BITS-1:0] in_dl;
	logic [TIME_BITS-1:0] in_now;
	assign in_id  = s_tdata[ID_BITS-1:0];
	assign in_dl  = s_tdata[ID_BITS +: TIME_BITS];
	assign in_now = s_tdata[ID_BITS + TIME_BITS +: TIME_BITS];

	// control state
	dtq_pkg::dtq_state_t  state_q, state_d;
	logic [AW-1:0]        head_q, head_d;    // slot of the earliest entry
	logic [CW-1:0]        count_q, count_d;  // entries queued
	logic [CW-1:0]        pos_q, pos_d;      // insert scan: candidate position
	logic                 have_q, have_d;    // a due entry is held back
	dtq_pkg::dtq_status_t fin_q, fin_d;      // status of the closing result

	// held item and held release (payload)
	logic [ID_BITS-1:0]   id_q, id_d;
	logic [TIME_BITS-1:0] dl_q, dl_d;
	logic [TIME_BITS-1:0] now_q, now_d;
	logic [ID_BITS-1:0]   held_id_q, held_id_d;
	logic [TIME_BITS-1:0] held_dl_q, held_dl_d;

	// output register
	logic                 m_tvalid_q, m_tvalid_d;
	dtq_pkg::dtq_status_t m_status_q, m_status_d;
	logic [ID_BITS-1:0]   m_id_q, m_id_d;
	logic [TIME_BITS-1:0] m_dl_q, m_dl_d;
	logic                 m_last_q, m_last_d;

	// RAM port
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [EW-1:0] ram_wdata, ram_rdata;
	logic [TIME_BITS-1:0] rd_dl;
	logic [ID_BITS-1:0]   rd_id;

	assign rd_dl = ram_rdata[TIME_BITS-1:0];
	assign rd_id = ram_rdata[EW-1:TIME_BITS];

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;

	dtq_ram #(
		.WIDTH (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dtq_pkg::S_IDLE;
			head_q     <= '0;
			count_q    <= '0;
			pos_q      <= '0;
			have_q     <= 1'b0;
			fin_q      <= dtq_pkg::ST_NONE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			count_q    <= count_d;
			pos_q      <= pos_d;
			have_q     <= have_d;
			fin_q      <= fin_d;
			m_tvalid_q <= m_tvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		id_q       <= id_d;
		dl_q       <= dl_d;
		now_q      <= now_d;
		held_id_q  <= held_id_d;
		held_dl_q  <= held_dl_d;
		m_status_q <= m_status_d;
		m_id_q     <= m_id_d;
		m_dl_q     <= m_dl_d;
		m_last_q   <= m_last_d;
	end

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		count_d    = count_q;
		pos_d      = pos_q;
		have_d     = have_q;
		fin_d      = fin_q;
		id_d       = id_q;
		dl_d       = dl_q;
		now_d      = now_q;
		held_id_d  = held_id_q;
		held_dl_d  = held_dl_q;
		m_tvalid_d = m_tvalid_q && !m_tready;
		m_status_d = m_status_q;
		m_id_d     = m_id_q;
		m_dl_d     = m_dl_q;
		m_last_d   = m_last_q;
		ram_we     = 1'b0;
		ram_waddr  = phys(head_q, pos_q);
		ram_wdata  = {id_q, dl_q};
		ram_re     = 1'b0;
		ram_raddr  = head_q;
		s_tready   = 1'b0;

		case (state_q)
			dtq_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					id_d   = in_id;
					dl_d   = in_dl;
					now_d  = in_now;
					have_d = 1'b0;
					if (s_tuser == dtq_pkg::ACT_TICK) begin
						state_d = dtq_pkg::S_TICK_RD;
					end else if (in_now > in_dl) begin
						fin_d   = dtq_pkg::ST_PAST;
						state_d = dtq_pkg::S_DONE;
					end else if (count_q == CW'(QUEUE_DEPTH)) begin
						fin_d   = dtq_pkg::ST_FULL;
						state_d = dtq_pkg::S_DONE;
					end else begin
						pos_d   = count_q;
						state_d = dtq_pkg::S_ADD_RD;
					end
				end
			end

			dtq_pkg::S_ADD_RD: begin
				if (pos_q == '0) begin
					ram_we  = 1'b1;
					count_d = count_q + CW'(1);
					fin_d   = dtq_pkg::ST_ADDED;
					state_d = dtq_pkg::S_DONE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = phys(head_q, pos_q - CW'(1));
					state_d   = dtq_pkg::S_ADD_CMP;
				end
			end

			dtq_pkg::S_ADD_CMP: begin
				ram_we = 1'b1;
				if (rd_dl > dl_q) begin
					// later entry moves up one slot, keep scanning down
					ram_wdata = ram_rdata;
					pos_d     = pos_q - CW'(1);
					state_d   = dtq_pkg::S_ADD_RD;
				end else begin
					count_d = count_q + CW'(1);
					fin_d   = dtq_pkg::ST_ADDED;
					state_d = dtq_pkg::S_DONE;
				end
			end

			dtq_pkg::S_TICK_RD: begin
				if (count_q == '0) begin
					fin_d   = have_q ? dtq_pkg::ST_RELEASED : dtq_pkg::ST_NONE;
					state_d = dtq_pkg::S_DONE;
				end else begin
					ram_re  = 1'b1;
					state_d = dtq_pkg::S_TICK_CMP;
				end
			end

			dtq_pkg::S_TICK_CMP: begin
				if (rd_dl <= now_q) begin
					// head is due: the held release is not the last one
					if (!have_q || out_free) begin
						if (have_q) begin
							m_tvalid_d = 1'b1;
							m_status_d = dtq_pkg::ST_RELEASED;
							m_id_d     = held_id_q;
							m_dl_d     = held_dl_q;
							m_last_d   = 1'b0;
						end
						held_id_d = rd_id;
						held_dl_d = rd_dl;
						have_d    = 1'b1;
						head_d    = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
						count_d   = count_q - CW'(1);
						state_d   = dtq_pkg::S_TICK_RD;
					end
				end else begin
					fin_d   = have_q ? dtq_pkg::ST_RELEASED : dtq_pkg::ST_NONE;
					state_d = dtq_pkg::S_DONE;
				end
			end

			dtq_pkg::S_DONE: begin
				if (out_free) begin
					m_tvalid_d = 1'b1;
					m_status_d = fin_q;
					m_last_d   = 1'b1;
					if (fin_q == dtq_pkg::ST_RELEASED) begin
						m_id_d = held_id_q;
						m_dl_d = held_dl_q;
					end else begin
						m_id_d = '0;
						m_dl_d = '0;
					end
					have_d  = 1'b0;
					state_d = dtq_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = dtq_pkg::S_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = OUT_TW'({m_dl_q, m_id_q});

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("fill count above queue depth");

	a_write_only_on_add: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == dtq_pkg::S_ADD_RD || state_q == dtq_pkg::S_ADD_CMP))
		else $error("RAM written outside insert scan");

	a_pop_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q < $past(count_q)) |-> ($past(state_q) == dtq_pkg::S_TICK_CMP))
		else $error("entries dropped outside a tick");

	a_nonlast_is_release: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_last_q) |-> (m_status_q == dtq_pkg::ST_RELEASED))
		else $error("non-final result that is not a release");
`endif

endmodule

@@ tb/deadline_task_queue_tb.sv @@
// ----------------------------------------------------------------------------
// deadline_task_queue_tb
// Self-checking bench for the deadline task queue: a directed table of items
// (typed-in outcomes where obvious, the rest predicted), then random items
// over several idle/stall phases with a long output hold-off.
// ----------------------------------------------------------------------------
module deadline_task_queue_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH = dtq_pkg::QUEUE_DEPTH_DEF;
	localparam int TIME_W = dtq_pkg::TIME_BITS_DEF;
	localparam int ID_W   = dtq_pkg::ID_BITS_DEF;
	localparam int IN_TW  = (((ID_W + 2 * TIME_W) + 7) / 8) * 8;
	localparam int OUT_TW = (((ID_W + TIME_W) + 7) / 8) * 8;

	localparam int RAND_PER_PHASE = 80;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 100;   // longer than the worst add or tick
	localparam int CYCLE_LIMIT    = 400000;

	localparam logic [TIME_W-1:0] T_MAX = '1;

	// one input item
	typedef struct {
		logic              action;
		logic [ID_W-1:0]   task_id;
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] now_time;
	} item_t;

	// one result item
	typedef struct {
		dtq_pkg::dtq_status_t status;
		logic [ID_W-1:0]      id;
		logic [TIME_W-1:0]    dl;
		logic                 is_last;
	} outcome_t;

	// directed row: item plus an optional typed-in single outcome
	typedef struct {
		item_t                it;
		bit                   typed;
		dtq_pkg::dtq_status_t want;
	} dir_row_t;

	logic              clk    = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [IN_TW-1:0]  s_tdata  = '0;   // task_id, deadline, now_time
	logic              s_tuser  = dtq_pkg::ACT_ADD;   // action
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_TW-1:0] m_tdata;         // released_id, released_deadline
	logic [2:0]        m_tuser;         // status
	logic              m_tlast;

	// bench-side copy of the queue, slot 0 due first
	logic [TIME_W-1:0] sched_dl [QDEPTH];
	logic [ID_W-1:0]   sched_id [QDEPTH];
	int                sched_cnt = 0;

	outcome_t outcomes_q[$];   // expected results, oldest first
	outcome_t fresh_q[$];      // outcomes of the item just accepted

	int                err_cnt = 0;
	int                tx_pct  = 0;   // sender idle chance, percent
	int                rx_pct  = 0;   // receiver stall chance, percent
	bit                hold_req = 1'b0;
	logic [TIME_W-1:0] clk_now = '0;  // running time for well-formed items
	longint            cycles = 0;

	deadline_task_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor: applies one accepted item to the bench queue and leaves its
	// outcomes in fresh_q. Insert goes after every entry due no later, so
	// equal deadlines leave in arrival order.
	function automatic void sched_apply(input item_t it);
		outcome_t o;
		int       pos;
		int       due;
		fresh_q.delete();
		o = '{status: dtq_pkg::ST_ADDED, id: '0, dl: '0, is_last: 1'b1};
		if (it.action == dtq_pkg::ACT_ADD) begin
			if (it.now_time > it.deadline) begin
				o.status = dtq_pkg::ST_PAST;        // past wins over full
			end else if (sched_cnt >= QDEPTH) begin
				o.status = dtq_pkg::ST_FULL;
			end else begin
				pos = 0;
				while (pos < sched_cnt && sched_dl[pos] <= it.deadline)
					pos++;
				for (int i = sched_cnt; i > pos; i--) begin
					sched_dl[i] = sched_dl[i-1];
					sched_id[i] = sched_id[i-1];
				end
				sched_dl[pos] = it.deadline;
				sched_id[pos] = it.task_id;
				sched_cnt++;
			end
			fresh_q.push_back(o);
		end else begin
			due = 0;
			while (due < sched_cnt && sched_dl[due] <= it.now_time)
				due++;
			if (due == 0) begin
				o.status = dtq_pkg::ST_NONE;
				fresh_q.push_back(o);
			end else begin
				for (int i = 0; i < due; i++) begin
					o.status  = dtq_pkg::ST_RELEASED;
					o.id      = sched_id[i];
					o.dl      = sched_dl[i];
					o.is_last = (i == due - 1);
					fresh_q.push_back(o);
				end
				for (int i = due; i < sched_cnt; i++) begin
					sched_dl[i-due] = sched_dl[i];
					sched_id[i-due] = sched_id[i];
				end
				sched_cnt -= due;
			end
		end
	endfunction

	// Random item. Mostly well-formed traffic around a running time so the
	// queue fills, ties and drains; a slice is raw noise over all bits.
	function automatic item_t rand_item();
		item_t       it;
		int unsigned r;
		r = $urandom_range(99);
		it.action   = dtq_pkg::ACT_ADD;
		it.task_id  = ID_W'($urandom);
		it.deadline = TIME_W'($urandom);
		it.now_time = TIME_W'($urandom);
		if (r < 8) begin
			it.action = 1'($urandom_range(1));
		end else if (r < 58) begin
			it.now_time = clk_now;
			it.deadline = clk_now + TIME_W'($urandom_range(24));
		end else if (r < 63) begin
			it.now_time = clk_now;
			it.deadline = clk_now - TIME_W'($urandom_range(1, 20));
		end else if (r < 66) begin
			it.action   = dtq_pkg::ACT_TICK;
			it.now_time = T_MAX;          // flush whatever is queued
		end else begin
			it.action   = dtq_pkg::ACT_TICK;
			clk_now     = clk_now + TIME_W'($urandom_range(12));
			it.now_time = clk_now;
		end
		return it;
	endfunction

	// Offer one item, wait for the handshake, then record what it must yield.
	// A gap is only opened here, so valid gets one assignment per step.
	task automatic send_item(input item_t it, input bit typed,
	                         input dtq_pkg::dtq_status_t want);
		if (tx_pct > 0 && $urandom_range(99) < tx_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= it.action;
		s_tdata  <= {it.now_time, it.deadline, it.task_id};
		do @(posedge clk); while (!s_tready);
		sched_apply(it);
		if (typed)
			outcomes_q.push_back('{status: want, id: '0, dl: '0, is_last: 1'b1});
		else
			foreach (fresh_q[i]) outcomes_q.push_back(fresh_q[i]);
	endtask

	// Receiver: random stalls by phase; on request a long hold-off so the
	// block backs up and drops s_tready.
	initial begin : rx_ctrl
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= !(rx_pct > 0 && $urandom_range(99) < rx_pct);
		end
	end

	// Result checker: every accepted result against the oldest expectation.
	always @(posedge clk) begin : res_chk
		outcome_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (outcomes_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected result, expected none, got status %0d id %0h dl %0h last %0b",
					$time, m_tuser, m_tdata[ID_W-1:0], m_tdata[ID_W +: TIME_W], m_tlast);
			end else begin
				w = outcomes_q.pop_front();
				if (m_tuser !== w.status) begin
					err_cnt++;
					$display("%0t: status expected %0d, got %0d", $time, w.status, m_tuser);
				end
				if (m_tdata[ID_W-1:0] !== w.id) begin
					err_cnt++;
					$display("%0t: released_id expected %0h, got %0h",
						$time, w.id, m_tdata[ID_W-1:0]);
				end
				if (m_tdata[ID_W +: TIME_W] !== w.dl) begin
					err_cnt++;
					$display("%0t: released_deadline expected %0h, got %0h",
						$time, w.dl, m_tdata[ID_W +: TIME_W]);
				end
				if (m_tlast !== w.is_last) begin
					err_cnt++;
					$display("%0t: last expected %0b, got %0b", $time, w.is_last, m_tlast);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("deadline_task_queue: mismatch");
			$finish;
		end
	end

	initial begin : stim
		dir_row_t dir_rows[$];
		// Directed table. Typed-in outcomes only where obvious: empty tick,
		// plain adds, past deadline, full. Releases come from the predictor.
		// empty queue tick
		dir_rows.push_back('{'{dtq_pkg::ACT_TICK, 8'h00, 32'h0, 32'h0}, 1'b1, dtq_pkg::ST_NONE});
		// extreme id/deadline, then deadline zero equal to now
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'hFF, T_MAX, 32'h0}, 1'b1, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h00, 32'h0, 32'h0}, 1'b1, dtq_pkg::ST_ADDED});
		// deadline one behind now
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h55, 32'd100, 32'd101}, 1'b1, dtq_pkg::ST_PAST});
		// deadline equal to now, then a tie at the same deadline
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'hAA, 32'd100, 32'd100}, 1'b1, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h01, 32'd100, 32'd5}, 1'b1, dtq_pkg::ST_ADDED});
		// tick with junk in the ignored fields: releases only id 00
		dir_rows.push_back('{'{dtq_pkg::ACT_TICK, 8'hFF, T_MAX, 32'd99}, 1'b0, dtq_pkg::ST_ADDED});
		// tie released in arrival order: AA then 01
		dir_rows.push_back('{'{dtq_pkg::ACT_TICK, 8'h00, 32'h0, 32'd100}, 1'b0, dtq_pkg::ST_ADDED});
		// fill up to capacity, unordered deadlines with ties
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h10, 32'd500, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h11, 32'd300, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h12, 32'd500, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h13, 32'd200, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h14, 32'd700, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h15, 32'd300, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h16, 32'd900, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h17, 32'd200, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h18, 32'd500, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h19, 32'd650, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h1A, 32'd300, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h1B, 32'd800, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h1C, 32'd100, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h1D, 32'd500, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h1E, 32'd1000, 32'd10}, 1'b0, dtq_pkg::ST_ADDED});
		// queue full; then past and full together, past wins
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h42, 32'd50, 32'd10}, 1'b1, dtq_pkg::ST_FULL});
		dir_rows.push_back('{'{dtq_pkg::ACT_ADD, 8'h43, 32'd5, 32'd10}, 1'b1, dtq_pkg::ST_PAST});
		// release all sixteen at max time
		dir_rows.push_back('{'{dtq_pkg::ACT_TICK, 8'h00, 32'h0, T_MAX}, 1'b0, dtq_pkg::ST_ADDED});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

		// Random phases: no idling (with the long hold-off), sender idle,
		// receiver stalling, both.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin tx_pct = 0;  rx_pct = 0;  hold_req = 1'b1; end
				1: begin tx_pct = 45; rx_pct = 0;  end
				2: begin tx_pct = 0;  rx_pct = 45; end
				default: begin tx_pct = 38; rx_pct = 38; end
			endcase
			clk_now = TIME_W'($urandom_range(32'hFFFF_F000));
			repeat (RAND_PER_PHASE) send_item(rand_item(), 1'b0, dtq_pkg::ST_ADDED);
		end
		s_tvalid <= 1'b0;

		while (outcomes_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_cnt == 0)
			$display("deadline_task_queue: match");
		else
			$display("deadline_task_queue: mismatch");
		$finish;
	end

endmodule
